FILE: design/particle_pair_overlap_resolver_top_defines.svh
// ----------------------------------------------------------------------------
// Particle pair overlap resolver assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_PAIR_OVERLAP_RESOLVER_TOP_DEFINES_SVH
`define PARTICLE_PAIR_OVERLAP_RESOLVER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Assertion that is switched off while reset is applied.
`define PPOR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("ppor assertion failed");
// Assertion that is checked on every edge, reset included.
`define PPOR_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("ppor assertion failed");
`else
`define PPOR_ASSERT(lbl, clk, rst_n, prop)
`define PPOR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: design/ppor_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pair overlap resolver package
// Field widths, pipeline stage map and the pipeline word type.
// ----------------------------------------------------------------------------
package ppor_pkg;

	localparam int unsigned ID_W     = 12;
	localparam int unsigned POS_W    = 16;
	localparam int unsigned RADIUS_W = 14;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 14'd328;

	localparam int unsigned ROOT_BITS = 23;  // sqrt of d2 * 2^16, d2 < 2^30
	localparam int unsigned Q_BITS    = 16;  // shift magnitude bits

	// Stage map of the pipeline.
	localparam int unsigned ST_DIFF  = 0;
	localparam int unsigned ST_SQ    = 1;
	localparam int unsigned ST_D2    = 2;
	localparam int unsigned ST_ROOT0 = 3;
	localparam int unsigned ST_V     = ST_ROOT0 + ROOT_BITS;
	localparam int unsigned ST_MUL   = ST_V + 1;
	localparam int unsigned ST_DIV0  = ST_MUL + 1;
	localparam int unsigned ST_OUT   = ST_DIV0 + Q_BITS + 1;
	localparam int unsigned N_STAGES = ST_OUT + 1;

	typedef struct packed {
		logic                    ne;      // ids differ
		logic                    act;     // correction applies
		logic [POS_W-1:0]        sx;
		logic [POS_W-1:0]        sy;
		logic [POS_W-1:0]        ox;
		logic [POS_W-1:0]        oy;
		logic signed [POS_W:0]   dx;
		logic signed [POS_W:0]   dy;
		logic [33:0]             sqx;
		logic [33:0]             sqy;
		logic [29:0]             diam;
		logic [33:0]             d2;
		logic [45:0]             rad;
		logic [25:0]             srem;
		logic [ROOT_BITS-1:0]    root;
		logic [22:0]             v;
		logic [POS_W-1:0]        magx;
		logic [POS_W-1:0]        magy;
		logic [38:0]             prodx;
		logic [38:0]             prody;
		logic [39:0]             remx;
		logic [39:0]             remy;
		logic [ROOT_BITS:0]      den;
		logic [Q_BITS-1:0]       qx;
		logic [Q_BITS-1:0]       qy;
		logic [POS_W-1:0]        nsx;
		logic [POS_W-1:0]        nsy;
		logic [POS_W-1:0]        nox;
		logic [POS_W-1:0]        noy;
	} pipe_t;

endpackage

FILE: design/ppor_pair_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pair input channel
// Valid/ready channel carrying one candidate pair per word.
// ----------------------------------------------------------------------------
interface ppor_pair_if;
	logic        valid;
	logic        ready;
	logic [11:0] self_id;
	logic [11:0] other_id;
	logic [15:0] self_x;
	logic [15:0] self_y;
	logic [15:0] other_x;
	logic [15:0] other_y;

	modport source (output valid, self_id, other_id, self_x, self_y, other_x, other_y,
		input ready);
	modport sink (input valid, self_id, other_id, self_x, self_y, other_x, other_y,
		output ready);
endinterface

FILE: design/ppor_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pair result channel
// Valid/ready channel carrying the corrected positions of one pair per word.
// ----------------------------------------------------------------------------
interface ppor_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] new_self_x;
	logic [15:0] new_self_y;
	logic [15:0] new_other_x;
	logic [15:0] new_other_y;
	logic        overlapped;

	modport source (output valid, new_self_x, new_self_y, new_other_x, new_other_y,
		overlapped, input ready);
	modport sink (input valid, new_self_x, new_self_y, new_other_x, new_other_y,
		overlapped, output ready);
endinterface

FILE: design/particle_pair_overlap_resolver_top.sv
`timescale 1ns / 1ps
// Pipeline: a pair word accepted into stage 0 moves through 46 stage registers,
// and the last one is the output register that offers the result word.
// Throughput: one pair per cycle; the 23-stage square root and 16-stage
// divider are fully pipelined, and the whole pipe advances whenever the
// output register is empty or being taken.
// Reset: clears all stage valid bits and loads the radius with 328.
// ----------------------------------------------------------------------------
// Particle pair overlap resolver
// Pushes two overlapping equal circles apart along their center line by half
// the overlap each, saturating the corrected positions to the unit box.
// ----------------------------------------------------------------------------
`include "particle_pair_overlap_resolver_top_defines.svh"

module particle_pair_overlap_resolver_top (
	input  logic                          clk,
	input  logic                          arst_n,
	ppor_pair_if.sink                     pair,
	ppor_result_if.source                 result,
	input  logic                          cfg_wr_en,
	input  logic [ppor_pkg::RADIUS_W-1:0] cfg_wr_data
);
	import ppor_pkg::*;

	localparam int unsigned LAST = N_STAGES - 1;

	logic [RADIUS_W-1:0] radius_q;
	pipe_t               pipe_s [N_STAGES];
	logic [N_STAGES-1:0] v_s;
	pipe_t               nxt    [N_STAGES];
	logic                en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_wr_en) begin
			radius_q <= cfg_wr_data;
		end
	end

	// The whole pipe moves together; the last stage is the output register.
	assign en         = !v_s[LAST] || result.ready;
	assign pair.ready = en;

	always_comb begin
		nxt[ST_DIFF]    = '0;
		nxt[ST_DIFF].ne = (pair.self_id != pair.other_id);
		nxt[ST_DIFF].sx = pair.self_x;
		nxt[ST_DIFF].sy = pair.self_y;
		nxt[ST_DIFF].ox = pair.other_x;
		nxt[ST_DIFF].oy = pair.other_y;
		nxt[ST_DIFF].dx = $signed({1'b0, pair.other_x}) - $signed({1'b0, pair.self_x});
		nxt[ST_DIFF].dy = $signed({1'b0, pair.other_y}) - $signed({1'b0, pair.self_y});
	end

	for (genvar g = 1; g < N_STAGES; g++) begin : g_stage
		always_comb begin
			logic [25:0]         rem_c;
			logic [25:0]         trial;
			logic [39:0]         cmp;
			logic signed [18:0]  shx;
			logic signed [18:0]  shy;
			logic signed [18:0]  t;
			nxt[g] = pipe_s[g-1];
			rem_c  = '0;
			trial  = '0;
			cmp    = '0;
			shx    = '0;
			shy    = '0;
			t      = '0;
			if (g == ST_SQ) begin
				nxt[g].sqx  = 34'(pipe_s[g-1].dx * pipe_s[g-1].dx);
				nxt[g].sqy  = 34'(pipe_s[g-1].dy * pipe_s[g-1].dy);
				nxt[g].diam = {28'(radius_q * radius_q), 2'b00};
			end else if (g == ST_D2) begin
				nxt[g].d2   = pipe_s[g-1].sqx + pipe_s[g-1].sqy;
				nxt[g].act  = pipe_s[g-1].ne && (nxt[g].d2 != '0)
					&& (nxt[g].d2 < {4'b0, pipe_s[g-1].diam});
				nxt[g].rad  = {nxt[g].d2[29:0], 16'h0000};
				nxt[g].srem = '0;
				nxt[g].root = '0;
			end else if (g >= ST_ROOT0 && g < ST_V) begin
				// One result bit of the square root per stage.
				rem_c = {pipe_s[g-1].srem[23:0], pipe_s[g-1].rad[45:44]};
				trial = {1'b0, pipe_s[g-1].root, 2'b01};
				nxt[g].rad = {pipe_s[g-1].rad[43:0], 2'b00};
				if (rem_c >= trial) begin
					nxt[g].srem = rem_c - trial;
					nxt[g].root = {pipe_s[g-1].root[ROOT_BITS-2:0], 1'b1};
				end else begin
					nxt[g].srem = rem_c;
					nxt[g].root = {pipe_s[g-1].root[ROOT_BITS-2:0], 1'b0};
				end
			end else if (g == ST_V) begin
				nxt[g].v    = {radius_q, 9'h000} - pipe_s[g-1].root;
				nxt[g].magx = pipe_s[g-1].dx[POS_W] ? POS_W'(-pipe_s[g-1].dx)
					: pipe_s[g-1].dx[POS_W-1:0];
				nxt[g].magy = pipe_s[g-1].dy[POS_W] ? POS_W'(-pipe_s[g-1].dy)
					: pipe_s[g-1].dy[POS_W-1:0];
			end else if (g == ST_MUL) begin
				nxt[g].prodx = 39'(pipe_s[g-1].magx * pipe_s[g-1].v);
				nxt[g].prody = 39'(pipe_s[g-1].magy * pipe_s[g-1].v);
			end else if (g == ST_DIV0) begin
				// Adding s before dividing by 2s rounds half away from zero.
				nxt[g].remx = {1'b0, pipe_s[g-1].prodx} + {17'b0, pipe_s[g-1].root};
				nxt[g].remy = {1'b0, pipe_s[g-1].prody} + {17'b0, pipe_s[g-1].root};
				nxt[g].den  = {pipe_s[g-1].root, 1'b0};
				nxt[g].qx   = '0;
				nxt[g].qy   = '0;
			end else if (g > ST_DIV0 && g < ST_OUT) begin
				cmp = {16'b0, pipe_s[g-1].den} << (Q_BITS - (g - ST_DIV0));
				if (pipe_s[g-1].remx >= cmp) begin
					nxt[g].remx = pipe_s[g-1].remx - cmp;
					nxt[g].qx   = pipe_s[g-1].qx | (Q_BITS'(1) << (Q_BITS - (g - ST_DIV0)));
				end
				if (pipe_s[g-1].remy >= cmp) begin
					nxt[g].remy = pipe_s[g-1].remy - cmp;
					nxt[g].qy   = pipe_s[g-1].qy | (Q_BITS'(1) << (Q_BITS - (g - ST_DIV0)));
				end
			end else begin
				shx = pipe_s[g-1].dx[POS_W] ? -$signed({3'b0, pipe_s[g-1].qx})
					: $signed({3'b0, pipe_s[g-1].qx});
				shy = pipe_s[g-1].dy[POS_W] ? -$signed({3'b0, pipe_s[g-1].qy})
					: $signed({3'b0, pipe_s[g-1].qy});
				if (!pipe_s[g-1].act) begin
					shx = '0;
					shy = '0;
				end
				t = $signed({3'b0, pipe_s[g-1].sx}) - shx;
				nxt[g].nsx = t[18] ? '0 : ((t[17:16] != 2'b00) ? '1 : t[15:0]);
				t = $signed({3'b0, pipe_s[g-1].sy}) - shy;
				nxt[g].nsy = t[18] ? '0 : ((t[17:16] != 2'b00) ? '1 : t[15:0]);
				t = $signed({3'b0, pipe_s[g-1].ox}) + shx;
				nxt[g].nox = t[18] ? '0 : ((t[17:16] != 2'b00) ? '1 : t[15:0]);
				t = $signed({3'b0, pipe_s[g-1].oy}) + shy;
				nxt[g].noy = t[18] ? '0 : ((t[17:16] != 2'b00) ? '1 : t[15:0]);
			end
		end
	end

	for (genvar g = 0; g < N_STAGES; g++) begin : g_reg
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= (g == 0) ? pair.valid : v_s[(g == 0) ? 0 : g-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pipe_s[g] <= nxt[g];
			end
		end
	end

	assign result.valid       = v_s[LAST];
	assign result.new_self_x  = pipe_s[LAST].nsx;
	assign result.new_self_y  = pipe_s[LAST].nsy;
	assign result.new_other_x = pipe_s[LAST].nox;
	assign result.new_other_y = pipe_s[LAST].noy;
	assign result.overlapped  = pipe_s[LAST].act;

	// The finished root is the floor square root of d2 * 2^16.
	`PPOR_ASSERT(a_root_exact, clk, arst_n, (v_s[ST_V-1] && pipe_s[ST_V-1].act) |-> ((48'(pipe_s[ST_V-1].root) * 48'(pipe_s[ST_V-1].root) <= {2'b00, pipe_s[ST_V-1].d2[29:0], 16'h0000}) && ((48'(pipe_s[ST_V-1].root) + 48'd1) * (48'(pipe_s[ST_V-1].root) + 48'd1) > {2'b00, pipe_s[ST_V-1].d2[29:0], 16'h0000})))
	// After the last divider step the remainders are below the divisor.
	`PPOR_ASSERT(a_div_rem, clk, arst_n, (v_s[ST_OUT-1] && pipe_s[ST_OUT-1].act) |-> ((pipe_s[ST_OUT-1].remx < 40'(pipe_s[ST_OUT-1].den)) && (pipe_s[ST_OUT-1].remy < 40'(pipe_s[ST_OUT-1].den))))
	// A correction is only ever reported for two distinct particles.
	`PPOR_ASSERT(a_flag_ids, clk, arst_n, (result.valid && result.overlapped) |-> pipe_s[LAST].ne)
	// A held result freezes the front of the pipe as well.
	`PPOR_ASSERT(a_stall_front, clk, arst_n, (v_s[LAST] && !result.ready) |=> (v_s[LAST] && $stable(pipe_s[0]) && $stable(v_s)))
	`PPOR_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> (v_s == '0))

endmodule

FILE: tb/ppor_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overlap resolver testbench channel note
// The pair and result channels are the design interfaces themselves; this
// file holds the small channel monitor used by the bench to count traffic.
// ----------------------------------------------------------------------------
interface ppor_tb_activity_if (input logic clk);
	logic accepted;
endinterface

FILE: tb/tb_particle_pair_overlap_resolver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Particle pair overlap resolver testbench
// Drives candidate pairs through the resolver under random bursts, gaps and
// output stalls, predicts every result word with a local fixed-point model of
// the circle push-apart and checks each word field by field in order.
// ----------------------------------------------------------------------------
module tb_particle_pair_overlap_resolver_top;
	import ppor_pkg::*;

	localparam int LATENCY = 46;
	localparam int IDLE_LIMIT = 4000;
	localparam int N_RANDOM = 500;

	typedef struct packed {
		logic [11:0] sid;
		logic [11:0] oid;
		logic [15:0] sx;
		logic [15:0] sy;
		logic [15:0] ox;
		logic [15:0] oy;
	} pair_t;

	typedef struct packed {
		logic [15:0] nsx;
		logic [15:0] nsy;
		logic [15:0] nox;
		logic [15:0] noy;
		logic        hit;
	} moved_t;

	typedef struct {
		pair_t  p;
		logic   known;
		moved_t m;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [RADIUS_W-1:0] cfg_wr_data = '0;

	ppor_pair_if pair ();
	ppor_result_if result ();
	ppor_tb_activity_if act (.clk(clk));

	particle_pair_overlap_resolver_top dut (
		.clk(clk), .arst_n(arst_n), .pair(pair.sink), .result(result.source),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	assign act.accepted = pair.valid && pair.ready;

	logic [RADIUS_W-1:0] radius_q = RADIUS_RESET;
	moved_t moved_q[$];
	int errors = 0;
	int idle = 0;
	int hold_off = 0;
	bit rx_quiet = 0;
	bit tx_done = 0;

	function automatic logic [63:0] root_of(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint push_of(input longint d, input longint v, input longint s);
		longint q;
		q = ((d < 0 ? -d : d) * v + s) / (2 * s);
		return d < 0 ? -q : q;
	endfunction

	function automatic logic [15:0] clamp_box(input longint v);
		if (v < 0) return 16'd0;
		if (v > 65535) return 16'hFFFF;
		return v[15:0];
	endfunction

	function automatic moved_t resolve_pair(input pair_t p, input logic [RADIUS_W-1:0] rad);
		moved_t m;
		longint dx, dy, d2, s, v, hx, hy, nsx, nsy, nox, noy;
		dx = longint'(p.ox) - longint'(p.sx);
		dy = longint'(p.oy) - longint'(p.sy);
		d2 = dx * dx + dy * dy;
		nsx = p.sx; nsy = p.sy; nox = p.ox; noy = p.oy;
		m.hit = 1'b0;
		if (p.sid != p.oid && d2 != 0 && d2 < 4 * longint'(rad) * longint'(rad)) begin
			s = root_of(d2 << 16);
			v = longint'(rad) * 512 - s;
			hx = push_of(dx, v, s);
			hy = push_of(dy, v, s);
			nsx -= hx; nsy -= hy; nox += hx; noy += hy;
			m.hit = 1'b1;
		end
		m.nsx = clamp_box(nsx);
		m.nsy = clamp_box(nsy);
		m.nox = clamp_box(nox);
		m.noy = clamp_box(noy);
		return m;
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		$display("mismatch %s at %0t", what, $realtime);
	endtask

	// Sampling and checking at the rising edge.
	always @(posedge act.clk) begin
		moved_t w;
		if (arst_n) begin
			if (act.accepted) begin
				moved_q = {moved_q, resolve_pair({pair.self_id, pair.other_id, pair.self_x,
					pair.self_y, pair.other_x, pair.other_y}, radius_q)};
			end
			if (cfg_wr_en) radius_q <= cfg_wr_data;
			if (act.accepted || (result.valid && result.ready)) idle = 0;
			else idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
			if (result.valid && result.ready) begin
				if (moved_q.size() == 0) begin
					report_mismatch("result word with no pair outstanding");
				end else begin
					w = moved_q.pop_front();
					if (result.new_self_x !== w.nsx)
						report_mismatch($sformatf("new_self_x: got %0d expected %0d",
							result.new_self_x, w.nsx));
					if (result.new_self_y !== w.nsy)
						report_mismatch($sformatf("new_self_y: got %0d expected %0d",
							result.new_self_y, w.nsy));
					if (result.new_other_x !== w.nox)
						report_mismatch($sformatf("new_other_x: got %0d expected %0d",
							result.new_other_x, w.nox));
					if (result.new_other_y !== w.noy)
						report_mismatch($sformatf("new_other_y: got %0d expected %0d",
							result.new_other_y, w.noy));
					if (result.overlapped !== w.hit)
						report_mismatch($sformatf("overlapped: got %0d expected %0d",
							result.overlapped, w.hit));
				end
			end
		end
	end

	// Receiver stall pattern, with a long hold-off on request.
	initial begin
		int phase;
		result.ready = 1'b0;
		phase = 0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				result.ready <= 1'b0;
				hold_off--;
			end else if (rx_quiet) begin
				result.ready <= 1'b1;
			end else begin
				phase++;
				case ((phase / 64) % 4)
					0: result.ready <= 1'b1;
					1: result.ready <= ($urandom_range(3) != 0);
					2: result.ready <= ($urandom_range(1) != 0);
					default: result.ready <= (phase % 7) < 2;
				endcase
			end
		end
	end

	int burst_left = 0;

	// Offers one word, with random burst gaps, and waits for its acceptance.
	task automatic send_pair(input pair_t p, input bit gaps);
		int gap;
		if (gaps && burst_left == 0) begin
			gap = $urandom_range(6);
			if (gap > 0) begin
				pair.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		pair.valid <= 1'b1;
		{pair.self_id, pair.other_id, pair.self_x, pair.self_y, pair.other_x,
			pair.other_y} <= p;
		@(posedge clk);
		while (!pair.ready) @(posedge clk);
		@(negedge clk);
		if (burst_left > 0) burst_left--;
	endtask

	task automatic drain_all();
		pair.valid <= 1'b0;
		while (moved_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic set_radius(input logic [RADIUS_W-1:0] r);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= r;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Near pair: the other particle sits within reach of the first on each axis.
	function automatic pair_t near_pair(input int reach);
		pair_t p;
		int ox, oy;
		p.sid = 12'($urandom);
		p.oid = ($urandom_range(15) == 0) ? p.sid : 12'($urandom);
		p.sx = 16'($urandom);
		p.sy = 16'($urandom);
		ox = int'(p.sx) + int'($urandom_range(2 * reach)) - reach;
		oy = int'(p.sy) + int'($urandom_range(2 * reach)) - reach;
		p.ox = (ox < 0) ? 16'd0 : (ox > 65535) ? 16'hFFFF : 16'(ox);
		p.oy = (oy < 0) ? 16'd0 : (oy > 65535) ? 16'hFFFF : 16'(oy);
		return p;
	endfunction

	row_t rows[$];
	localparam logic [RADIUS_W-1:0] RADII[5] = '{14'd1, 14'd16383, 14'd2000, 14'd40, 14'd328};

	task automatic add_row(input pair_t p, input logic known, input moved_t m);
		row_t r;
		r.p = p;
		r.known = known;
		r.m = m;
		rows = {rows, r};
	endtask

	initial begin
		moved_t w;
		pair_t p;
		pair.valid = 1'b0;
		{pair.self_id, pair.other_id, pair.self_x, pair.self_y, pair.other_x,
			pair.other_y} = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table at the reset radius; echoes are typed in.
		add_row('{12'd5, 12'd5, 16'd100, 16'd100, 16'd101, 16'd100}, 1'b1,
			'{16'd100, 16'd100, 16'd101, 16'd100, 1'b0});
		add_row('{12'd1, 12'd2, 16'd500, 16'd500, 16'd500, 16'd500}, 1'b1,
			'{16'd500, 16'd500, 16'd500, 16'd500, 1'b0});
		add_row('{12'd1, 12'd2, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF}, 1'b1,
			'{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0});
		add_row('{12'hFFF, 12'd0, 16'd1000, 16'd1000, 16'd1656, 16'd1000}, 1'b1,
			'{16'd1000, 16'd1000, 16'd1656, 16'd1000, 1'b0});
		add_row('{12'd0, 12'hFFF, 16'd0, 16'd0, 16'd10, 16'd0}, 1'b0, '0);
		add_row('{12'd3, 12'd4, 16'hFFFF, 16'hFFFF, 16'hFFF0, 16'hFFFF}, 1'b0, '0);
		add_row('{12'd3, 12'd4, 16'd200, 16'd300, 16'd210, 16'd290}, 1'b0, '0);
		add_row('{12'hAAA, 12'h555, 16'hAAAA, 16'h5555, 16'hAAAB, 16'h5555}, 1'b0, '0);
		add_row('{12'h555, 12'hAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAA9}, 1'b0, '0);
		add_row('{12'd7, 12'd8, 16'd1000, 16'd1000, 16'd1655, 16'd1000}, 1'b0, '0);
		foreach (rows[i]) begin
			if (rows[i].known) begin
				w = resolve_pair(rows[i].p, radius_q);
				if (w !== rows[i].m)
					report_mismatch($sformatf("predictor against table row %0d", i));
			end
			send_pair(rows[i].p, 1'b0);
		end
		drain_all();

		foreach (RADII[k]) begin
			set_radius(RADII[k]);
			for (int i = 0; i < N_RANDOM / 5; i++) begin
				if ($urandom_range(9) < 8) p = near_pair(2 * int'(RADII[k]) + 4);
				else p = 88'({$urandom, $urandom, $urandom});
				if (k == 2 && i == 20) hold_off = 300;
				send_pair(p, 1'b1);
			end
			// Sender pauses until every word is back; the receiver is held ready only for the second radius.
			rx_quiet = (k == 1);
			drain_all();
			rx_quiet = 0;
		end

		// Edge pushes against the box walls at the largest radius.
		set_radius(14'd16383);
		for (int i = 0; i < 20; i++) begin
			p = near_pair(3000);
			p.sx = (i % 2) ? 16'hFFFF : 16'd0;
			send_pair(p, 1'b1);
		end
		drain_all();

		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule
